>>> sv/vntc_pkg.sv
package vntc_pkg;

  localparam int unsigned MaxVetoHits = 64;
  localparam int unsigned AddrW = (MaxVetoHits > 1) ? $clog2(MaxVetoHits) : 1;
  localparam int unsigned CntW = $clog2(MaxVetoHits + 1);

  localparam int unsigned EnergyW = 32;
  localparam int unsigned TimeW = 32;
  localparam int unsigned DtW = TimeW + 1;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [1:0] ModeVeto = 2'd0;
  localparam logic [1:0] ModeDet = 2'd1;
  localparam logic [1:0] ModeEoe = 2'd2;

  localparam logic [1:0] ClassNone = 2'd0;
  localparam logic [1:0] ClassInside = 2'd1;
  localparam logic [1:0] ClassOutside = 2'd2;

  localparam logic [CfgIdxW-1:0] RegVetoThr = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDetLow = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDetHigh = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCoincWin = 3'd3;
  localparam logic [CfgIdxW-1:0] RegWideWin = 3'd4;

  typedef struct packed {
    logic wr_veto;
    logic clr_event;
    logic start_scan;
    logic rd_step;
    logic cmp_step;
    logic load_out;
  } vntc_cmd_t;

  typedef struct packed {
    logic veto_ok;
    logic det_ok;
    logic table_empty;
    logic scan_last;
  } vntc_sts_t;

endpackage

>>> sv/vntc_dp.sv
module vntc_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  vntc_pkg::vntc_cmd_t            cmd_i,
  output vntc_pkg::vntc_sts_t            sts_o,
  input  logic [vntc_pkg::EnergyW-1:0]   energy_ev_i,
  input  logic [vntc_pkg::TimeW-1:0]     hit_time_ns_i,
  input  logic                           cfg_we_i,
  input  logic [vntc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [vntc_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic [1:0]                     hit_class_o,
  output logic                           outside_wide_o,
  output logic signed [vntc_pkg::DtW-1:0] nearest_dt_ns_o,
  output logic                           veto_overflow_o
);
  import vntc_pkg::*;

  logic [CfgDataW-1:0] veto_thr_q, det_low_q, det_high_q, coinc_win_q, wide_win_q;
  logic [CntW-1:0]     count_q;
  logic                ovf_q;
  logic [AddrW-1:0]    idx_q;
  logic [TimeW-1:0]    mem_q [MaxVetoHits];
  logic [TimeW-1:0]    rdata_q;
  logic [TimeW-1:0]    t_q;
  logic                found_q;
  logic [TimeW-1:0]    best_abs_q;
  logic [DtW-1:0]      best_dt_q;
  logic [1:0]          class_q;
  logic                wide_q;
  logic [DtW-1:0]      dt_q;
  logic                ovf_out_q;

  logic                full;
  logic [DtW-1:0]      cur_dt;
  logic [TimeW-1:0]    cur_abs;
  logic                better;

  assign full = (count_q == CntW'(MaxVetoHits));
  assign sts_o.veto_ok = (energy_ev_i > veto_thr_q);
  assign sts_o.det_ok = (energy_ev_i > det_low_q) && (energy_ev_i < det_high_q);
  assign sts_o.table_empty = (count_q == '0);
  assign sts_o.scan_last = ((CntW'(idx_q) + CntW'(1)) == count_q);

  assign cur_dt = {1'b0, t_q} - {1'b0, rdata_q};
  assign cur_abs = (t_q >= rdata_q) ? (t_q - rdata_q) : (rdata_q - t_q);
  assign better = !found_q || (cur_abs < best_abs_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      veto_thr_q  <= CfgDataW'(100000);
      det_low_q   <= CfgDataW'(10000);
      det_high_q  <= CfgDataW'(200000);
      coinc_win_q <= CfgDataW'(2500);
      wide_win_q  <= CfgDataW'(25000);
      count_q     <= '0;
      ovf_q       <= 1'b0;
      idx_q       <= '0;
      found_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          RegVetoThr:  veto_thr_q <= cfg_data_i;
          RegDetLow:   det_low_q <= cfg_data_i;
          RegDetHigh:  det_high_q <= cfg_data_i;
          RegCoincWin: coinc_win_q <= cfg_data_i;
          RegWideWin:  wide_win_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.clr_event) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
      end else if (cmd_i.wr_veto) begin
        if (full) begin
          ovf_q <= 1'b1;
        end else begin
          count_q <= count_q + CntW'(1);
        end
      end
      if (cmd_i.start_scan) begin
        idx_q   <= '0;
        found_q <= 1'b0;
      end else begin
        if (cmd_i.rd_step) begin
          idx_q <= idx_q + AddrW'(1);
        end
        if (cmd_i.cmp_step) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_veto && !full) begin
      mem_q[count_q[AddrW-1:0]] <= hit_time_ns_i;
    end
    if (cmd_i.rd_step) begin
      rdata_q <= mem_q[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_scan) begin
      t_q <= hit_time_ns_i;
    end
    if (cmd_i.cmp_step && better) begin
      best_abs_q <= cur_abs;
      best_dt_q  <= cur_dt;
    end
    if (cmd_i.load_out) begin
      ovf_out_q <= ovf_q;
      if (found_q) begin
        class_q <= (best_abs_q >= coinc_win_q) ? ClassOutside : ClassInside;
        wide_q  <= (best_abs_q >= wide_win_q);
        dt_q    <= best_dt_q;
      end else begin
        class_q <= ClassNone;
        wide_q  <= 1'b0;
        dt_q    <= '0;
      end
    end
  end

  assign hit_class_o = class_q;
  assign outside_wide_o = wide_q;
  assign nearest_dt_ns_o = $signed(dt_q);
  assign veto_overflow_o = ovf_out_q;

endmodule

>>> sv/vntc_ctrl.sv
module vntc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          mode_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output vntc_pkg::vntc_cmd_t cmd_o,
  input  vntc_pkg::vntc_sts_t sts_i
);
  import vntc_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDrain,
    StFinish
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   cmp_q, cmp_d;
  logic   accept;
  logic   out_free;

  assign accept = in_valid_i && (state_q == StIdle);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.cmp_step = cmp_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          unique case (mode_i)
            ModeVeto: cmd_o.wr_veto = sts_i.veto_ok;
            ModeEoe:  cmd_o.clr_event = 1'b1;
            ModeDet: begin
              if (sts_i.det_ok) begin
                cmd_o.start_scan = 1'b1;
                state_d = sts_i.table_empty ? StFinish : StScan;
              end
            end
            default: ;
          endcase
        end
      end
      StScan: begin
        cmd_o.rd_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StFinish;
      end
      StFinish: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
    cmp_d = cmd_o.rd_step;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      cmp_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cmp_q       <= cmp_d;
    end
  end

  assign in_stall_o = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

endmodule

>>> sv/veto_nearest_time_coincidence_core.sv
// Channel  Handshake                 Payload
// -------  ------------------------  --------------------------------------------
// in       in_valid_i / in_stall_o   mode_i, energy_ev_i, hit_time_ns_i
// out      out_valid_o / out_stall_i hit_class_o, outside_wide_o, nearest_dt_ns_o,
//                                    veto_overflow_o
// cfg      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Veto hits, end-of-event and rejected items are handled in the idle state.
// A qualifying detector hit steps through the scan, drain and finish states
// (straight to finish when the table is empty): the veto time memory is read
// one entry per cycle through one read port, with each compare in the cycle after its read.
// Reset empties the table and loads the register defaults; no clearing pass.
// The result sits in an output register; a stalled result holds the block only
// when the next detector result is ready to be loaded.
module veto_nearest_time_coincidence_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      mode_i,
  input  logic [vntc_pkg::EnergyW-1:0]    energy_ev_i,
  input  logic [vntc_pkg::TimeW-1:0]      hit_time_ns_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      hit_class_o,
  output logic                            outside_wide_o,
  output logic signed [vntc_pkg::DtW-1:0] nearest_dt_ns_o,
  output logic                            veto_overflow_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [vntc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [vntc_pkg::CfgDataW-1:0]   cfg_data_i
);
  import vntc_pkg::*;

  vntc_cmd_t cmd;
  vntc_sts_t sts;

  assign cfg_ready_o = 1'b1;

  vntc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  vntc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .energy_ev_i     (energy_ev_i),
    .hit_time_ns_i   (hit_time_ns_i),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .hit_class_o     (hit_class_o),
    .outside_wide_o  (outside_wide_o),
    .nearest_dt_ns_o (nearest_dt_ns_o),
    .veto_overflow_o (veto_overflow_o)
  );

endmodule
